/* rtl/core/bale_pkg.sv */
// Package for the bounded array list engine.
// Holds command, status and opcode constants and the word and control types.
// No dependencies; every other file of the block imports it.
`default_nettype none

package bale_pkg;

	localparam int KEY_W = 32;
	localparam int PAY_W = 32;
	localparam int POS_W = 7;
	localparam int CNT_W = 8;
	localparam int REC_W = KEY_W + PAY_W;

	localparam logic [3:0] CMD_INSERT_AT    = 4'd0;
	localparam logic [3:0] CMD_INSERT_FRONT = 4'd1;
	localparam logic [3:0] CMD_INSERT_BACK  = 4'd2;
	localparam logic [3:0] CMD_REMOVE_AT    = 4'd3;
	localparam logic [3:0] CMD_REMOVE_FRONT = 4'd4;
	localparam logic [3:0] CMD_REMOVE_BACK  = 4'd5;
	localparam logic [3:0] CMD_REMOVE_KEY   = 4'd6;
	localparam logic [3:0] CMD_FIND_KEY     = 4'd7;
	localparam logic [3:0] CMD_READ_AT      = 4'd8;
	localparam logic [3:0] CMD_COUNT_KEY    = 4'd9;

	localparam logic [1:0] STS_OK       = 2'd0;
	localparam logic [1:0] STS_RANGE    = 2'd1;
	localparam logic [1:0] STS_EMPTY    = 2'd2;
	localparam logic [1:0] STS_NOTFOUND = 2'd3;

	localparam logic [2:0] OP_NONE    = 3'd0;
	localparam logic [2:0] OP_UP      = 3'd1;
	localparam logic [2:0] OP_DN      = 3'd2;
	localparam logic [2:0] OP_COMPACT = 3'd3;
	localparam logic [2:0] OP_FIND    = 3'd4;
	localparam logic [2:0] OP_READ    = 3'd5;
	localparam logic [2:0] OP_COUNT   = 3'd6;

	localparam logic [1:0] TOT_NONE = 2'd0;
	localparam logic [1:0] TOT_INC  = 2'd1;
	localparam logic [1:0] TOT_DEC  = 2'd2;
	localparam logic [1:0] TOT_SET  = 2'd3;

	typedef struct packed {
		logic [3:0]             cmd;
		logic signed [KEY_W-1:0] key;
		logic [PAY_W-1:0]       payload;
		logic [POS_W-1:0]       position;
	} bale_req_t;

	typedef struct packed {
		logic [1:0]              status;
		logic signed [KEY_W-1:0] found_key;
		logic [PAY_W-1:0]        found_payload;
		logic [CNT_W-1:0]        match_count;
		logic [CNT_W-1:0]        entry_count;
		logic                    is_empty;
		logic                    is_full;
	} bale_rsp_t;

	typedef struct packed {
		logic       load;
		logic       rd_en;
		logic [2:0] op;
		logic       wr_new;
		logic [1:0] tot_op;
		logic       set_status;
		logic [1:0] status;
		logic       publish;
	} bale_ctl_t;

	typedef struct packed {
		logic hit;
		logic found;
	} bale_sts_t;

endpackage

`default_nettype wire

/* rtl/core/bale_req_if.sv */
// Request channel of the list engine: valid, ready and a request word.
// Depends on bale_pkg for the word type.
`default_nettype none

interface bale_req_if import bale_pkg::*; ();
	logic      valid;
	logic      ready;
	bale_req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/bale_rsp_if.sv */
// Response channel of the list engine: valid, ready and a response word.
// Depends on bale_pkg for the word type.
`default_nettype none

interface bale_rsp_if import bale_pkg::*; ();
	logic      valid;
	logic      ready;
	bale_rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/bale_datapath.sv */
// Datapath of the list engine: record memory, read stage, entry count,
// search and count logic and the response register. Depends on bale_pkg.
`default_nettype none

module bale_datapath import bale_pkg::*; #(
	parameter int DEPTH = 128,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire bale_ctl_t     ctl,
	input  wire logic [AW-1:0] addr,
	input  wire bale_req_t     req_word,
	output logic [CW-1:0]      total,
	output bale_sts_t          sts,
	output bale_rsp_t          rsp_word
);

	logic [REC_W-1:0] store_q [DEPTH];
	logic [REC_W-1:0] rd_data_s1;
	logic [AW-1:0]    rd_addr_s1;
	logic             rd_vld_s1;

	logic [KEY_W-1:0] key_q;
	logic [PAY_W-1:0] pay_q;
	logic [CW-1:0]    total_q;
	logic [CW-1:0]    w_q;
	logic [CW-1:0]    mc_q;
	logic             hit_q;
	logic             found_q;
	logic [KEY_W-1:0] fk_q;
	logic [PAY_W-1:0] fp_q;
	logic [1:0]       status_q;
	bale_rsp_t        rsp_q;

	logic             s1_match;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [REC_W-1:0] wr_data;

	assign s1_match = rd_vld_s1 && (rd_data_s1[REC_W-1:PAY_W] == key_q);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr;
		wr_data = {key_q, pay_q};
		if (ctl.wr_new) begin
			wr_en = 1'b1;
		end else if (rd_vld_s1) begin
			wr_data = rd_data_s1;
			case (ctl.op)
				OP_UP: begin
					wr_en   = 1'b1;
					wr_addr = rd_addr_s1 + AW'(1);
				end
				OP_DN: begin
					wr_en   = 1'b1;
					wr_addr = rd_addr_s1 - AW'(1);
				end
				OP_COMPACT: begin
					wr_en   = !s1_match;
					wr_addr = w_q[AW-1:0];
				end
				default: begin
					wr_en = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_s1 <= store_q[addr];
			rd_addr_s1 <= addr;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			key_q <= req_word.key;
			pay_q <= req_word.payload;
		end
		if (ctl.publish) begin
			rsp_q.status        <= status_q;
			rsp_q.found_key     <= fk_q;
			rsp_q.found_payload <= fp_q;
			rsp_q.match_count   <= CNT_W'(mc_q);
			rsp_q.entry_count   <= CNT_W'(total_q);
			rsp_q.is_empty      <= (total_q == '0);
			rsp_q.is_full       <= (total_q == CW'(DEPTH));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			total_q   <= '0;
			w_q       <= '0;
			mc_q      <= '0;
			hit_q     <= 1'b0;
			found_q   <= 1'b0;
			fk_q      <= '0;
			fp_q      <= '0;
			status_q  <= STS_OK;
		end else begin
			rd_vld_s1 <= ctl.rd_en;
			if (ctl.load) begin
				w_q      <= '0;
				mc_q     <= '0;
				hit_q    <= 1'b0;
				found_q  <= 1'b0;
				fk_q     <= '0;
				fp_q     <= '0;
				status_q <= STS_OK;
			end else begin
				if (ctl.set_status) begin
					status_q <= ctl.status;
				end
				if (rd_vld_s1) begin
					case (ctl.op)
						OP_COMPACT: begin
							if (s1_match) begin
								hit_q <= 1'b1;
							end else begin
								w_q <= w_q + CW'(1);
							end
						end
						OP_FIND: begin
							if (s1_match && !found_q) begin
								found_q <= 1'b1;
								fk_q    <= rd_data_s1[REC_W-1:PAY_W];
								fp_q    <= rd_data_s1[PAY_W-1:0];
							end
						end
						OP_READ: begin
							fk_q <= rd_data_s1[REC_W-1:PAY_W];
							fp_q <= rd_data_s1[PAY_W-1:0];
						end
						OP_COUNT: begin
							if (s1_match) begin
								mc_q <= mc_q + CW'(1);
							end
						end
						default: begin
						end
					endcase
				end
			end
			case (ctl.tot_op)
				TOT_INC:  total_q <= total_q + CW'(1);
				TOT_DEC:  total_q <= total_q - CW'(1);
				TOT_SET:  total_q <= w_q;
				default:  total_q <= total_q;
			endcase
		end
	end

	assign total     = total_q;
	assign sts.hit   = hit_q;
	assign sts.found = found_q;
	assign rsp_word  = rsp_q;

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.wr_new && rd_vld_s1))
		else $error("new record write collides with a moving entry");

	a_total_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.tot_op == TOT_NONE) |=> $stable(total_q))
		else $error("entry count moved without an update");

endmodule

`default_nettype wire

/* rtl/core/bale_ctrl.sv */
// Controller of the list engine: decodes a request word, checks bounds,
// sequences the memory walk and hands the result to the response register.
// Depends on bale_pkg; drives bale_datapath through a bale_ctl_t word.
`default_nettype none

module bale_ctrl import bale_pkg::*; #(
	parameter int DEPTH = 128,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire bale_req_t     req_word,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	input  wire logic [CW-1:0] total,
	input  wire bale_sts_t     sts,
	output bale_ctl_t          ctl,
	output logic [AW-1:0]      addr
);

	localparam int XW = (CW > POS_W) ? CW : POS_W;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_DECIDE  = 3'd1;
	localparam logic [2:0] ST_SCAN    = 3'd2;
	localparam logic [2:0] ST_DRAIN   = 3'd3;
	localparam logic [2:0] ST_FINISH  = 3'd4;
	localparam logic [2:0] ST_PUBLISH = 3'd5;

	logic [2:0]       state_q;
	logic [2:0]       nxt_state;
	logic [3:0]       cmd_q;
	logic [POS_W-1:0] pos_q;
	logic [AW-1:0]    ptr_q;
	logic [AW-1:0]    nxt_ptr;
	logic [AW-1:0]    end_q;
	logic [AW-1:0]    nxt_end;
	logic [AW-1:0]    pe_q;
	logic [AW-1:0]    nxt_pe;
	logic [2:0]       op_q;
	logic [2:0]       nxt_op;
	logic             out_vld_q;

	logic [XW-1:0]    tot_x;
	logic [XW-1:0]    pos_x;
	logic [XW-1:0]    last_x;
	logic [XW-1:0]    ins_x;
	logic [XW-1:0]    rem_x;
	logic             full;
	logic             empty;

	assign tot_x  = XW'(total);
	assign pos_x  = XW'(pos_q);
	assign last_x = tot_x - XW'(1);
	assign full   = (total == CW'(DEPTH));
	assign empty  = (total == '0);
	assign ins_x  = (cmd_q == CMD_INSERT_FRONT) ? '0 :
	                (cmd_q == CMD_INSERT_BACK)  ? tot_x : pos_x;
	assign rem_x  = (cmd_q == CMD_REMOVE_FRONT) ? '0 :
	                (cmd_q == CMD_REMOVE_BACK)  ? last_x : pos_x;

	always_comb begin
		ctl       = '0;
		ctl.op    = op_q;
		addr      = ptr_q;
		nxt_state = state_q;
		nxt_ptr   = ptr_q;
		nxt_end   = end_q;
		nxt_pe    = pe_q;
		nxt_op    = op_q;
		req_ready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					ctl.load  = 1'b1;
					nxt_state = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				nxt_state = ST_PUBLISH;
				case (cmd_q)
					CMD_INSERT_AT, CMD_INSERT_FRONT, CMD_INSERT_BACK: begin
						if (full || ins_x > tot_x) begin
							ctl.set_status = 1'b1;
							ctl.status     = STS_RANGE;
						end else begin
							nxt_pe = AW'(ins_x);
							if (ins_x == tot_x) begin
								nxt_state = ST_FINISH;
							end else begin
								nxt_ptr   = AW'(last_x);
								nxt_end   = AW'(ins_x);
								nxt_op    = OP_UP;
								nxt_state = ST_SCAN;
							end
						end
					end
					CMD_REMOVE_AT, CMD_REMOVE_FRONT, CMD_REMOVE_BACK: begin
						if (empty) begin
							ctl.set_status = 1'b1;
							ctl.status     = STS_EMPTY;
						end else if (rem_x >= tot_x) begin
							ctl.set_status = 1'b1;
							ctl.status     = STS_RANGE;
						end else if (rem_x == last_x) begin
							nxt_state = ST_FINISH;
						end else begin
							nxt_ptr   = AW'(rem_x + XW'(1));
							nxt_end   = AW'(last_x);
							nxt_op    = OP_DN;
							nxt_state = ST_SCAN;
						end
					end
					CMD_REMOVE_KEY, CMD_FIND_KEY, CMD_COUNT_KEY: begin
						if (empty) begin
							if (cmd_q != CMD_COUNT_KEY) begin
								ctl.set_status = 1'b1;
								ctl.status     = STS_EMPTY;
							end
						end else begin
							nxt_ptr   = '0;
							nxt_end   = AW'(last_x);
							nxt_op    = (cmd_q == CMD_REMOVE_KEY) ? OP_COMPACT :
							            (cmd_q == CMD_FIND_KEY)   ? OP_FIND : OP_COUNT;
							nxt_state = ST_SCAN;
						end
					end
					CMD_READ_AT: begin
						if (empty) begin
							ctl.set_status = 1'b1;
							ctl.status     = STS_EMPTY;
						end else if (pos_x >= tot_x) begin
							ctl.set_status = 1'b1;
							ctl.status     = STS_RANGE;
						end else begin
							nxt_ptr   = AW'(pos_x);
							nxt_end   = AW'(pos_x);
							nxt_op    = OP_READ;
							nxt_state = ST_SCAN;
						end
					end
					default: begin
						nxt_state = ST_PUBLISH;
					end
				endcase
			end
			ST_SCAN: begin
				ctl.rd_en = 1'b1;
				if (ptr_q == end_q) begin
					nxt_state = ST_DRAIN;
				end else if (op_q == OP_UP) begin
					nxt_ptr = ptr_q - AW'(1);
				end else begin
					nxt_ptr = ptr_q + AW'(1);
				end
			end
			ST_DRAIN: begin
				nxt_state = ST_FINISH;
			end
			ST_FINISH: begin
				nxt_state = ST_PUBLISH;
				case (cmd_q)
					CMD_INSERT_AT, CMD_INSERT_FRONT, CMD_INSERT_BACK: begin
						ctl.wr_new = 1'b1;
						ctl.tot_op = TOT_INC;
						addr       = pe_q;
					end
					CMD_REMOVE_AT, CMD_REMOVE_FRONT, CMD_REMOVE_BACK: begin
						ctl.tot_op = TOT_DEC;
					end
					CMD_REMOVE_KEY: begin
						ctl.tot_op     = TOT_SET;
						ctl.set_status = 1'b1;
						ctl.status     = sts.hit ? STS_OK : STS_NOTFOUND;
					end
					CMD_FIND_KEY: begin
						ctl.set_status = 1'b1;
						ctl.status     = sts.found ? STS_OK : STS_NOTFOUND;
					end
					default: begin
						ctl.tot_op = TOT_NONE;
					end
				endcase
			end
			ST_PUBLISH: begin
				if (!out_vld_q || rsp_ready) begin
					ctl.publish = 1'b1;
					nxt_state   = ST_IDLE;
				end
			end
			default: begin
				nxt_state = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cmd_q     <= '0;
			pos_q     <= '0;
			ptr_q     <= '0;
			end_q     <= '0;
			pe_q      <= '0;
			op_q      <= OP_NONE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= nxt_state;
			ptr_q   <= nxt_ptr;
			end_q   <= nxt_end;
			pe_q    <= nxt_pe;
			op_q    <= nxt_op;
			if (ctl.load) begin
				cmd_q <= req_word.cmd;
				pos_q <= req_word.position;
			end
			if (ctl.publish) begin
				out_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_vld_q;

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == ST_DECIDE))
		else $error("accepted word not decoded next cycle");

	a_publish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.publish |=> out_vld_q)
		else $error("published result not presented");

endmodule

`default_nettype wire

/* rtl/core/bounded_array_list_engine.sv */
// Commands without a walk go from accept through decode, and finish if needed, to publish;
// commands that shift, compact, search or count walk their entries between decode and finish,
// one memory read per cycle on the single read port, then drain before finish.
// One command at a time; a new word is taken while the last result waits.
// Reset clears the entry count and control; record memory is not cleared.
// Depends on bale_pkg, bale_req_if, bale_rsp_if, bale_ctrl and bale_datapath.
`default_nettype none

module bounded_array_list_engine import bale_pkg::*; #(
	parameter int DEPTH = 128
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bale_req_if.sink   request,
	bale_rsp_if.source response
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	bale_ctl_t     ctl;
	bale_sts_t     sts;
	logic [AW-1:0] addr;
	logic [CW-1:0] total;
	logic          req_ready;
	logic          rsp_valid;
	bale_rsp_t     rsp_word;

	bale_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (request.valid),
		.req_ready (req_ready),
		.req_word  (request.data),
		.rsp_valid (rsp_valid),
		.rsp_ready (response.ready),
		.total     (total),
		.sts       (sts),
		.ctl       (ctl),
		.addr      (addr)
	);

	bale_datapath #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.addr     (addr),
		.req_word (request.data),
		.total    (total),
		.sts      (sts),
		.rsp_word (rsp_word)
	);

	assign request.ready  = req_ready;
	assign response.valid = rsp_valid;
	assign response.data  = rsp_word;

endmodule

`default_nettype wire

/* bench/tb_bounded_array_list_engine.sv */
// Testbench for bounded_array_list_engine: directed table, then random command phases.
// Results are checked field by field against table entries or an in-bench list model.
// Depends on bale_pkg, bale_req_if, bale_rsp_if and the engine RTL.
`default_nettype none

module tb_bounded_array_list_engine;
	import bale_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 128;
	localparam int LIMIT_CYCLES = 400_000;
	localparam int LONG_HOLD = 400;
	localparam int POOL_N = 8;
	localparam int N_PHASES = 4;
	localparam int PHASE_LEN [N_PHASES] = '{180, 100, 130, 90};
	localparam int PHASE_INS [N_PHASES] = '{95, 50, 8, 60};

	localparam logic [3:0] CMD_UNUSED_LO = 4'd10;
	localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

	typedef struct {
		bale_req_t word;
		bit        typed;
		bale_rsp_t rsp;
	} step_t;

	logic clk = 1'b0;
	logic arst_n;

	bale_req_if request_ch ();
	bale_rsp_if response_ch ();

	bounded_array_list_engine #(.DEPTH(DEPTH)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request_ch),
		.response (response_ch)
	);

	always #5ns clk = ~clk;

	logic [KEY_W-1:0] list_key [DEPTH];
	logic [PAY_W-1:0] list_pay [DEPTH];
	int               list_len = 0;

	bale_rsp_t        pending_rsps [$];
	step_t            step_list [$];
	logic [KEY_W-1:0] key_pool [POOL_N];
	int               mismatch_count = 0;
	int               words_seen = 0;
	int               cycle_count = 0;
	int               tx_burst = 0;
	int               rx_burst = 0;
	bit               long_hold_done = 1'b0;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic void list_drop(input int at);
		int i;
		for (i = at; i + 1 < list_len; i++) begin
			list_key[i] = list_key[i+1];
			list_pay[i] = list_pay[i+1];
		end
		list_len--;
	endfunction

	function automatic bale_rsp_t list_apply(input bale_req_t r);
		bale_rsp_t rsp;
		int        at;
		int        i;
		bit        hit;
		rsp = '0;
		hit = 1'b0;
		at  = int'(r.position);
		case (r.cmd)
			CMD_INSERT_AT, CMD_INSERT_FRONT, CMD_INSERT_BACK: begin
				if (r.cmd == CMD_INSERT_FRONT) at = 0;
				if (r.cmd == CMD_INSERT_BACK) at = list_len;
				if (list_len >= DEPTH || at > list_len) begin
					rsp.status = STS_RANGE;
				end else begin
					for (i = list_len; i > at; i--) begin
						list_key[i] = list_key[i-1];
						list_pay[i] = list_pay[i-1];
					end
					list_key[at] = r.key;
					list_pay[at] = r.payload;
					list_len++;
				end
			end
			CMD_REMOVE_AT, CMD_REMOVE_FRONT, CMD_REMOVE_BACK: begin
				if (list_len == 0) begin
					rsp.status = STS_EMPTY;
				end else begin
					if (r.cmd == CMD_REMOVE_FRONT) at = 0;
					if (r.cmd == CMD_REMOVE_BACK) at = list_len - 1;
					if (at >= list_len) rsp.status = STS_RANGE;
					else list_drop(at);
				end
			end
			CMD_REMOVE_KEY: begin
				if (list_len == 0) begin
					rsp.status = STS_EMPTY;
				end else begin
					i = 0;
					while (i < list_len) begin
						if (list_key[i] == r.key) begin
							list_drop(i);
							hit = 1'b1;
						end else begin
							i++;
						end
					end
					if (!hit) rsp.status = STS_NOTFOUND;
				end
			end
			CMD_FIND_KEY: begin
				if (list_len == 0) begin
					rsp.status = STS_EMPTY;
				end else begin
					rsp.status = STS_NOTFOUND;
					for (i = 0; i < list_len && !hit; i++) begin
						if (list_key[i] == r.key) begin
							rsp.found_key     = list_key[i];
							rsp.found_payload = list_pay[i];
							rsp.status        = STS_OK;
							hit               = 1'b1;
						end
					end
				end
			end
			CMD_READ_AT: begin
				if (list_len == 0) begin
					rsp.status = STS_EMPTY;
				end else if (at >= list_len) begin
					rsp.status = STS_RANGE;
				end else begin
					rsp.found_key     = list_key[at];
					rsp.found_payload = list_pay[at];
				end
			end
			CMD_COUNT_KEY: begin
				for (i = 0; i < list_len; i++)
					if (list_key[i] == r.key) rsp.match_count++;
			end
			default: begin
			end
		endcase
		rsp.entry_count = CNT_W'(list_len);
		rsp.is_empty    = (list_len == 0);
		rsp.is_full     = (list_len >= DEPTH);
		return rsp;
	endfunction

	function automatic void add_step(input logic [3:0] cmd, input logic [KEY_W-1:0] key,
			input logic [PAY_W-1:0] pay, input logic [POS_W-1:0] pos, input bit typed,
			input logic [1:0] st, input logic [KEY_W-1:0] fk, input logic [PAY_W-1:0] fp,
			input logic [CNT_W-1:0] mc, input logic [CNT_W-1:0] ec);
		step_t s;
		s.word.cmd          = cmd;
		s.word.key          = key;
		s.word.payload      = pay;
		s.word.position     = pos;
		s.typed             = typed;
		s.rsp.status        = st;
		s.rsp.found_key     = fk;
		s.rsp.found_payload = fp;
		s.rsp.match_count   = mc;
		s.rsp.entry_count   = ec;
		s.rsp.is_empty      = (ec == 0);
		s.rsp.is_full       = (ec == DEPTH);
		step_list.push_back(s);
	endfunction

	function automatic int draw_wait(ref int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) burst = $urandom_range(8, 30);
		return $urandom_range(0, 8);
	endfunction

	function automatic bale_req_t draw_command(input int insert_pct);
		bale_req_t w;
		int        sel;
		int        span;
		span = (list_len > DEPTH - 1) ? DEPTH - 1 : list_len;
		w.key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_N - 1)]
			: $urandom;
		w.payload = $urandom;
		w.position = ($urandom_range(0, 4) != 0) ? POS_W'($urandom_range(0, span))
			: POS_W'($urandom_range(0, DEPTH - 1));
		if ($urandom_range(0, 99) < insert_pct) begin
			sel = $urandom_range(0, 2);
			w.cmd = (sel == 0) ? CMD_INSERT_AT : (sel == 1) ? CMD_INSERT_FRONT : CMD_INSERT_BACK;
		end else begin
			sel = $urandom_range(0, 99);
			if (sel < 15) w.cmd = CMD_REMOVE_AT;
			else if (sel < 30) w.cmd = CMD_REMOVE_FRONT;
			else if (sel < 45) w.cmd = CMD_REMOVE_BACK;
			else if (sel < 55) w.cmd = CMD_REMOVE_KEY;
			else if (sel < 70) w.cmd = CMD_FIND_KEY;
			else if (sel < 85) w.cmd = CMD_READ_AT;
			else if (sel < 97) w.cmd = CMD_COUNT_KEY;
			else w.cmd = 4'($urandom_range(int'(CMD_UNUSED_LO), int'(CMD_UNUSED_HI)));
		end
		return w;
	endfunction

	task automatic send_word(input bale_req_t word, input bit typed, input bale_rsp_t typed_rsp);
		bale_rsp_t predicted;
		int        gap;
		gap = draw_wait(tx_burst);
		if (gap > 0) begin
			request_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		request_ch.data  <= word;
		request_ch.valid <= 1'b1;
		do @(posedge clk); while (request_ch.ready !== 1'b1);
		predicted = list_apply(word);
		pending_rsps.push_back(typed ? typed_rsp : predicted);
	endtask

	function automatic void check_word(input bale_rsp_t got);
		bale_rsp_t want;
		if (pending_rsps.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("unexpected result word: status %0d key %h payload %h count %0d",
					got.status, got.found_key, got.found_payload, got.entry_count);
			return;
		end
		want = pending_rsps.pop_front();
		if (got.status !== want.status || got.found_key !== want.found_key ||
				got.found_payload !== want.found_payload ||
				got.match_count !== want.match_count ||
				got.entry_count !== want.entry_count ||
				got.is_empty !== want.is_empty || got.is_full !== want.is_full) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display({"mismatch (exp/got): status %0d/%0d key %h/%h payload %h/%h ",
					"match %0d/%0d count %0d/%0d empty %b/%b full %b/%b"},
					want.status, got.status, want.found_key, got.found_key,
					want.found_payload, got.found_payload, want.match_count, got.match_count,
					want.entry_count, got.entry_count, want.is_empty, got.is_empty,
					want.is_full, got.is_full);
		end
	endfunction

	initial begin
		int hold;
		response_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			hold = draw_wait(rx_burst);
			if (!long_hold_done && words_seen >= 150) begin
				hold           = LONG_HOLD;
				long_hold_done = 1'b1;
			end
			if (hold > 0) begin
				response_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			response_ch.ready <= 1'b1;
			do @(posedge clk); while (response_ch.valid !== 1'b1);
			check_word(response_ch.data);
			words_seen++;
		end
	end

	initial begin
		int        p;
		int        n;
		int        i;
		bale_rsp_t none;
		none = '0;
		arst_n           <= 1'b0;
		request_ch.valid <= 1'b0;
		request_ch.data  <= '0;

		add_step(CMD_REMOVE_FRONT, 0, 0, 7'd0, 1, STS_EMPTY, 0, 0, 0, 8'd0);
		add_step(CMD_REMOVE_AT, 0, 0, 7'd127, 1, STS_EMPTY, 0, 0, 0, 8'd0);
		add_step(CMD_READ_AT, 0, 0, 7'd0, 1, STS_EMPTY, 0, 0, 0, 8'd0);
		add_step(CMD_FIND_KEY, 0, 0, 7'd0, 1, STS_EMPTY, 0, 0, 0, 8'd0);
		add_step(CMD_REMOVE_KEY, 0, 0, 7'd0, 1, STS_EMPTY, 0, 0, 0, 8'd0);
		add_step(CMD_COUNT_KEY, 0, 0, 7'd0, 1, STS_OK, 0, 0, 0, 8'd0);
		add_step(CMD_REMOVE_BACK, 0, 0, 7'd0, 1, STS_EMPTY, 0, 0, 0, 8'd0);
		add_step(CMD_INSERT_AT, 0, 0, 7'd1, 1, STS_RANGE, 0, 0, 0, 8'd0);
		add_step(CMD_UNUSED_HI, 0, 0, 7'd0, 1, STS_OK, 0, 0, 0, 8'd0);
		add_step(CMD_INSERT_AT, 32'h8000_0000, 32'hFFFF_FFFF, 7'd0, 1, STS_OK, 0, 0, 0, 8'd1);
		add_step(CMD_INSERT_FRONT, 32'h7FFF_FFFF, 0, 7'd0, 1, STS_OK, 0, 0, 0, 8'd2);
		add_step(CMD_INSERT_BACK, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 7'd0, 1, STS_OK, 0, 0, 0, 8'd3);
		add_step(CMD_INSERT_AT, 0, 32'hA5A5_A5A5, 7'd1, 1, STS_OK, 0, 0, 0, 8'd4);
		add_step(CMD_INSERT_AT, 32'h8000_0000, 32'h1, 7'd4, 1, STS_OK, 0, 0, 0, 8'd5);
		add_step(CMD_INSERT_AT, 0, 0, 7'd127, 1, STS_RANGE, 0, 0, 0, 8'd5);
		add_step(CMD_READ_AT, 0, 0, 7'd0, 1, STS_OK, 32'h7FFF_FFFF, 0, 0, 8'd5);
		add_step(CMD_READ_AT, 0, 0, 7'd5, 1, STS_RANGE, 0, 0, 0, 8'd5);
		add_step(CMD_READ_AT, 0, 0, 7'd127, 1, STS_RANGE, 0, 0, 0, 8'd5);
		add_step(CMD_FIND_KEY, 32'h8000_0000, 0, 7'd0, 1, STS_OK, 32'h8000_0000, 32'hFFFF_FFFF,
			0, 8'd5);
		add_step(CMD_COUNT_KEY, 32'h8000_0000, 0, 7'd0, 1, STS_OK, 0, 0, 8'd2, 8'd5);
		add_step(CMD_FIND_KEY, 32'h1234_5678, 0, 7'd0, 1, STS_NOTFOUND, 0, 0, 0, 8'd5);
		add_step(CMD_REMOVE_KEY, 32'h1234_5678, 0, 7'd0, 1, STS_NOTFOUND, 0, 0, 0, 8'd5);
		add_step(CMD_REMOVE_KEY, 32'h8000_0000, 0, 7'd0, 1, STS_OK, 0, 0, 0, 8'd3);
		add_step(CMD_REMOVE_AT, 0, 0, 7'd3, 1, STS_RANGE, 0, 0, 0, 8'd3);
		add_step(CMD_REMOVE_AT, 0, 0, 7'd1, 0, STS_OK, 0, 0, 0, 0);
		add_step(CMD_REMOVE_BACK, 0, 0, 7'd0, 0, STS_OK, 0, 0, 0, 0);
		add_step(CMD_REMOVE_FRONT, 0, 0, 7'd0, 1, STS_OK, 0, 0, 0, 8'd0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (step_list[s])
			send_word(step_list[s].word, step_list[s].typed, step_list[s].rsp);

		for (p = 0; p < N_PHASES; p++) begin
			for (i = 0; i < POOL_N; i++) key_pool[i] = $urandom;
			for (n = 0; n < PHASE_LEN[p]; n++)
				send_word(draw_command(PHASE_INS[p]), 1'b0, none);
		end

		request_ch.valid <= 1'b0;
		while (pending_rsps.size() != 0) @(posedge clk);
		repeat (DEPTH + 10) @(posedge clk);

		if (mismatch_count == 0 && pending_rsps.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
